// ===== rtl/jpeg_huffman_token_encoder_top_macros.svh =====
// Assertion macros shared by the Huffman token encoder modules.
`ifndef JPEG_HUFFMAN_TOKEN_ENCODER_TOP_MACROS_SVH
`define JPEG_HUFFMAN_TOKEN_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define JHTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define JHTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/jhte_pkg.sv =====
// Shared constants, types and codes of the Huffman token encoder.
package jhte_pkg;

  localparam int BLOCK_COEFFS  = 64;
  localparam int DC_CATEGORIES = 12;
  localparam int AC_SIZES      = 11;
  localparam int MAX_CODE_LEN  = 16;
  localparam int AC_ROWS       = 16;
  localparam int ZERO_RUN      = 15;

  localparam int CODE_W    = 16;
  localparam int LEN_W     = 5;
  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int ENTRY_W   = CODE_W + LEN_W;

  localparam int DC_BASE   = AC_ROWS * AC_SIZES;
  localparam int TAB_DEPTH = DC_BASE + DC_CATEGORIES;
  localparam int TAB_AW    = $clog2(TAB_DEPTH);

  localparam int CNT_W  = $clog2(BLOCK_COEFFS + 16);
  localparam int BYTE_W = 8;
  localparam int ACC_W  = BYTE_W - 1;
  localparam int FILL_W = 3;
  localparam int PACK_W = ACC_W + LEN_LIMIT;
  localparam int TOT_W  = $clog2(PACK_W + 1);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_DC_WR = 2'd0,
    MODE_AC_WR = 2'd1,
    MODE_TOKEN = 2'd2,
    MODE_FLUSH = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    PH_DC,
    PH_DC_RAW,
    PH_AC_RUN,
    PH_AC_SIZE,
    PH_AC_RAW
  } phase_t;

  typedef enum logic [1:0] {
    OP_CODE,
    OP_RAW,
    OP_FLUSH
  } op_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } entry_t;

  // Work handed from the parser to the bit packer.
  typedef struct packed {
    logic valid;
    op_t  op;
    logic raw_bit;
  } pkt_t;

endpackage

// ===== rtl/jhte_ram.sv =====
// Generic RAM with one write port and one registered read port.
module jhte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/jhte_parser.sv =====
// Token parser: table writes, block parse state and code table read issue.
`include "jpeg_huffman_token_encoder_top_macros.svh"

module jhte_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    mode,
  input  logic [3:0]                    token,
  input  logic [3:0]                    entry_row,
  input  logic [3:0]                    entry_col,
  input  logic [jhte_pkg::CODE_W-1:0]   code_bits,
  input  logic [jhte_pkg::LEN_W-1:0]    code_length,
  input  logic                          pack_ready,
  output jhte_pkg::pkt_t                s1,
  output logic                          ram_we,
  output logic [jhte_pkg::TAB_AW-1:0]   ram_waddr,
  output jhte_pkg::entry_t              ram_wdata,
  output logic                          ram_re,
  output logic [jhte_pkg::TAB_AW-1:0]   ram_raddr
);

  jhte_pkg::phase_t                 phase, phase_next;
  logic [3:0]                       raw_left, raw_left_next;
  logic [jhte_pkg::CNT_W-1:0]       coeff_count, cnt_next;
  logic [3:0]                       held_run, run_next;
  jhte_pkg::pkt_t                   s1_next;

  logic                             accept;
  logic [jhte_pkg::CNT_W-1:0]       ac_cnt;
  logic [jhte_pkg::CNT_W-1:0]       zr_cnt;
  logic [3:0]                       raw_dec;
  logic [jhte_pkg::LEN_W-1:0]       len_sat;
  logic [jhte_pkg::CODE_W:0]        len_mask;

  assign in_ready = !s1.valid || pack_ready;
  assign accept   = in_valid && in_ready;

  // Table entries are stored with the length saturated and the code masked to it.
  assign len_sat  = (code_length > jhte_pkg::LEN_W'(jhte_pkg::LEN_LIMIT)) ?
                    jhte_pkg::LEN_W'(jhte_pkg::LEN_LIMIT) : code_length;
  assign len_mask = ((jhte_pkg::CODE_W+1)'(1) << len_sat) - (jhte_pkg::CODE_W+1)'(1);
  assign ram_wdata.len  = len_sat;
  assign ram_wdata.code = code_bits & len_mask[jhte_pkg::CODE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= jhte_pkg::PH_DC;
      raw_left    <= '0;
      coeff_count <= jhte_pkg::CNT_W'(1);
      held_run    <= '0;
      s1          <= '0;
    end else begin
      phase       <= phase_next;
      raw_left    <= raw_left_next;
      coeff_count <= cnt_next;
      held_run    <= run_next;
      s1          <= s1_next;
    end
  end

  always_comb begin
    phase_next    = phase;
    raw_left_next = raw_left;
    cnt_next      = coeff_count;
    run_next      = held_run;
    s1_next       = s1;
    if (pack_ready) begin
      s1_next.valid = 1'b0;
    end
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    ac_cnt  = coeff_count + jhte_pkg::CNT_W'(held_run) + jhte_pkg::CNT_W'(1);
    zr_cnt  = coeff_count + jhte_pkg::CNT_W'(jhte_pkg::ZERO_RUN);
    raw_dec = raw_left - 4'd1;

    if (accept) begin
      case (jhte_pkg::mode_t'(mode))
        jhte_pkg::MODE_DC_WR: begin
          if (entry_row < jhte_pkg::DC_CATEGORIES) begin
            ram_we    = 1'b1;
            ram_waddr = jhte_pkg::TAB_AW'(jhte_pkg::DC_BASE) + jhte_pkg::TAB_AW'(entry_row);
          end
        end
        jhte_pkg::MODE_AC_WR: begin
          if (entry_col < jhte_pkg::AC_SIZES) begin
            ram_we    = 1'b1;
            ram_waddr = jhte_pkg::TAB_AW'(entry_row) * jhte_pkg::TAB_AW'(jhte_pkg::AC_SIZES)
                        + jhte_pkg::TAB_AW'(entry_col);
          end
        end
        jhte_pkg::MODE_FLUSH: begin
          s1_next.valid   = 1'b1;
          s1_next.op      = jhte_pkg::OP_FLUSH;
          s1_next.raw_bit = 1'b0;
        end
        jhte_pkg::MODE_TOKEN: begin
          case (phase)
            jhte_pkg::PH_DC: begin
              if (token < jhte_pkg::DC_CATEGORIES) begin
                ram_re          = 1'b1;
                ram_raddr       = jhte_pkg::TAB_AW'(jhte_pkg::DC_BASE)
                                  + jhte_pkg::TAB_AW'(token);
                s1_next.valid   = 1'b1;
                s1_next.op      = jhte_pkg::OP_CODE;
                s1_next.raw_bit = 1'b0;
                cnt_next        = jhte_pkg::CNT_W'(1);
                raw_left_next   = token;
                phase_next      = (token != 4'd0) ? jhte_pkg::PH_DC_RAW : jhte_pkg::PH_AC_RUN;
              end
            end
            jhte_pkg::PH_DC_RAW: begin
              s1_next.valid   = 1'b1;
              s1_next.op      = jhte_pkg::OP_RAW;
              s1_next.raw_bit = token[0];
              raw_left_next   = raw_dec;
              if (raw_dec == 4'd0) begin
                phase_next = jhte_pkg::PH_AC_RUN;
              end
            end
            jhte_pkg::PH_AC_RUN: begin
              run_next   = token;
              phase_next = jhte_pkg::PH_AC_SIZE;
            end
            jhte_pkg::PH_AC_SIZE: begin
              if (token < jhte_pkg::AC_SIZES) begin
                ram_re          = 1'b1;
                ram_raddr       = jhte_pkg::TAB_AW'(held_run)
                                  * jhte_pkg::TAB_AW'(jhte_pkg::AC_SIZES)
                                  + jhte_pkg::TAB_AW'(token);
                s1_next.valid   = 1'b1;
                s1_next.op      = jhte_pkg::OP_CODE;
                s1_next.raw_bit = 1'b0;
                if (held_run == 4'd0 && token == 4'd0) begin
                  // End of block.
                  phase_next = jhte_pkg::PH_DC;
                end else if (held_run == 4'(jhte_pkg::ZERO_RUN) && token == 4'd0) begin
                  cnt_next   = zr_cnt;
                  phase_next = (zr_cnt >= jhte_pkg::CNT_W'(jhte_pkg::BLOCK_COEFFS)) ?
                               jhte_pkg::PH_DC : jhte_pkg::PH_AC_RUN;
                end else begin
                  cnt_next      = ac_cnt;
                  raw_left_next = token;
                  if (token != 4'd0) begin
                    phase_next = jhte_pkg::PH_AC_RAW;
                  end else begin
                    phase_next = (ac_cnt >= jhte_pkg::CNT_W'(jhte_pkg::BLOCK_COEFFS)) ?
                                 jhte_pkg::PH_DC : jhte_pkg::PH_AC_RUN;
                  end
                end
              end
            end
            jhte_pkg::PH_AC_RAW: begin
              s1_next.valid   = 1'b1;
              s1_next.op      = jhte_pkg::OP_RAW;
              s1_next.raw_bit = token[0];
              raw_left_next   = raw_dec;
              if (raw_dec == 4'd0) begin
                phase_next = (coeff_count >= jhte_pkg::CNT_W'(jhte_pkg::BLOCK_COEFFS)) ?
                             jhte_pkg::PH_DC : jhte_pkg::PH_AC_RUN;
              end
            end
            default: begin
              phase_next = jhte_pkg::PH_DC;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  `JHTE_ASSERT_IMP(a_raw_left_live, phase == jhte_pkg::PH_DC_RAW || phase == jhte_pkg::PH_AC_RAW, raw_left != 4'd0, "raw bit phase with no raw bits left")
  `JHTE_ASSERT_IMP(a_run_in_block, phase == jhte_pkg::PH_AC_RUN, coeff_count < jhte_pkg::CNT_W'(jhte_pkg::BLOCK_COEFFS), "AC run expected past end of block")
  `JHTE_ASSERT_NXT(a_stage_hold, s1.valid && !pack_ready, $stable(s1), "stalled packer work changed")

endmodule

// ===== rtl/jhte_packer.sv =====
// Packer: appends codes and raw bits MSB first, queues whole bytes, pads on flush.
`include "jpeg_huffman_token_encoder_top_macros.svh"

module jhte_packer (
  input  logic                          clk,
  input  logic                          rst,
  input  jhte_pkg::pkt_t                s1,
  input  jhte_pkg::entry_t              entry,
  output logic                          pack_ready,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic [jhte_pkg::BYTE_W-1:0]   m_byte,
  output logic                          m_last
);

  logic [jhte_pkg::ACC_W-1:0]    acc, acc_next;
  logic [jhte_pkg::FILL_W-1:0]   fill, fill_next;
  logic [jhte_pkg::BYTE_W:0]     fifo [jhte_pkg::FIFO_DEPTH];
  logic [jhte_pkg::FIFO_AW-1:0]  wr_ptr, rd_ptr;
  logic [jhte_pkg::FIFO_CW-1:0]  count;

  logic                          take;
  logic                          pop;
  logic [jhte_pkg::LEN_W-1:0]    n;
  logic [jhte_pkg::CODE_W-1:0]   code;
  logic [jhte_pkg::PACK_W-1:0]   val;
  logic [jhte_pkg::TOT_W-1:0]    total;
  logic [jhte_pkg::TOT_W-1:0]    rem;
  logic [jhte_pkg::BYTE_W-1:0]   b0, b1;
  logic [1:0]                    nb;

  assign pack_ready = count <= jhte_pkg::FIFO_CW'(jhte_pkg::FIFO_DEPTH - 2);
  assign take       = s1.valid && pack_ready;
  assign pop        = m_valid && m_ready;
  assign m_valid    = count != '0;
  assign m_byte     = fifo[rd_ptr][jhte_pkg::BYTE_W-1:0];
  assign m_last     = fifo[rd_ptr][jhte_pkg::BYTE_W];

  always_comb begin
    n    = '0;
    code = '0;
    case (s1.op)
      jhte_pkg::OP_CODE: begin
        n    = entry.len;
        code = entry.code;
      end
      jhte_pkg::OP_RAW: begin
        n    = jhte_pkg::LEN_W'(1);
        code = jhte_pkg::CODE_W'(s1.raw_bit);
      end
      default: begin
      end
    endcase
    val   = (jhte_pkg::PACK_W'(acc) << n) | jhte_pkg::PACK_W'(code);
    total = jhte_pkg::TOT_W'(fill) + jhte_pkg::TOT_W'(n);
    b0    = jhte_pkg::BYTE_W'(val >> (total - jhte_pkg::TOT_W'(8)));
    b1    = jhte_pkg::BYTE_W'(val >> (total - jhte_pkg::TOT_W'(16)));
    nb    = 2'd0;
    rem   = total;
    if (total >= jhte_pkg::TOT_W'(16)) begin
      nb  = 2'd2;
      rem = total - jhte_pkg::TOT_W'(16);
    end else if (total >= jhte_pkg::TOT_W'(8)) begin
      nb  = 2'd1;
      rem = total - jhte_pkg::TOT_W'(8);
    end
    fill_next = jhte_pkg::FILL_W'(rem);
    // A remainder of seven wraps the shifted one to zero, leaving an all-ones mask.
    acc_next  = jhte_pkg::ACC_W'(val)
                & ((jhte_pkg::ACC_W'(1) << fill_next) - jhte_pkg::ACC_W'(1));
    if (s1.op == jhte_pkg::OP_FLUSH) begin
      nb        = (fill != '0) ? 2'd1 : 2'd0;
      b0        = jhte_pkg::BYTE_W'(acc) << (4'd8 - {1'b0, fill});
      fill_next = '0;
      acc_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc    <= '0;
      fill   <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (take) begin
        acc    <= acc_next;
        fill   <= fill_next;
        wr_ptr <= wr_ptr + jhte_pkg::FIFO_AW'(nb);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + jhte_pkg::FIFO_AW'(1);
      end
      count <= count + (take ? jhte_pkg::FIFO_CW'(nb) : '0) - jhte_pkg::FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (take && nb != 2'd0) begin
      fifo[wr_ptr] <= {nb == 2'd1, b0};
    end
    if (take && nb == 2'd2) begin
      fifo[wr_ptr + jhte_pkg::FIFO_AW'(1)] <= {1'b1, b1};
    end
  end

  `JHTE_ASSERT_IMP(a_fifo_bound, 1'b1, count <= jhte_pkg::FIFO_CW'(jhte_pkg::FIFO_DEPTH), "byte queue overfilled")
  `JHTE_ASSERT_NXT(a_flush_clears, take && s1.op == jhte_pkg::OP_FLUSH, fill == '0, "flush left bits in the packer")
  `JHTE_ASSERT_NXT(a_byte_done, take && s1.op == jhte_pkg::OP_RAW && fill == 3'd7, count != '0, "completed byte not queued")

endmodule

// ===== rtl/jpeg_huffman_token_encoder_top.sv =====
// Top level of the JPEG Huffman token encoder.
//
// Input channel s_axis: one transaction per item. tuser carries the mode (write DC
// entry, write AC entry, token, flush); tdata carries the token, the table entry
// position and the code with its length. Output channel m_axis: one packed byte
// per transaction, first bit in the MSB, tlast on the final byte of an item.
// An item is taken every cycle while the output keeps up. A token's code is read
// from the code table RAM at the accepting edge, and the packer queues its bytes
// when it takes the item from the packer stage, which waits while fewer than two
// queue entries are free. A byte queue of four entries takes at most two bytes per
// item and the output drains one byte per cycle while the receiver is ready, so
// items that complete two bytes each run at half rate in the long run. When the
// receiver stalls, the queue fills and s_axis_tready drops while the packer stage
// holds work and fewer than two queue entries are free.
// Reset returns the parse to the DC category of a new block and empties the packer
// and the queue. The code tables are not cleared and must be loaded before use.
module jpeg_huffman_token_encoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // token[3:0], entry_row[7:4], entry_col[11:8], code_bits[27:12], code_length[32:28]
  input  logic [39:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast
);

  jhte_pkg::pkt_t                 s1;
  jhte_pkg::entry_t               ram_wdata;
  jhte_pkg::entry_t               ram_rdata;
  logic                           ram_we;
  logic                           ram_re;
  logic [jhte_pkg::TAB_AW-1:0]    ram_waddr;
  logic [jhte_pkg::TAB_AW-1:0]    ram_raddr;
  logic                           pack_ready;

  jhte_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .mode        (s_axis_tuser),
    .token       (s_axis_tdata[3:0]),
    .entry_row   (s_axis_tdata[7:4]),
    .entry_col   (s_axis_tdata[11:8]),
    .code_bits   (s_axis_tdata[27:12]),
    .code_length (s_axis_tdata[32:28]),
    .pack_ready  (pack_ready),
    .s1          (s1),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr)
  );

  jhte_ram #(
    .WIDTH (jhte_pkg::ENTRY_W),
    .DEPTH (jhte_pkg::TAB_DEPTH)
  ) u_code_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  jhte_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .s1         (s1),
    .entry      (ram_rdata),
    .pack_ready (pack_ready),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .m_byte     (m_axis_tdata),
    .m_last     (m_axis_tlast)
  );

endmodule
